// File: hdl/assert_macros.svh
// Assertion macros shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// File: hdl/cau_pkg.sv
// Types, codes and helpers of the complex arithmetic unit.
package cau_pkg;
	localparam logic [2:0] FUNC_ADD  = 3'd0;
	localparam logic [2:0] FUNC_SUB  = 3'd1;
	localparam logic [2:0] FUNC_MUL  = 3'd2;
	localparam logic [2:0] FUNC_DIV  = 3'd3;
	localparam logic [2:0] FUNC_CONJ = 3'd4;
	localparam logic [2:0] FUNC_MAG  = 3'd5;

	localparam logic [1:0] STATUS_OK  = 2'd0;
	localparam logic [1:0] STATUS_DZ  = 2'd1;
	localparam logic [1:0] STATUS_SAT = 2'd2;

	// Kind of work that the back end performs for an item.
	localparam logic [1:0] KIND_DONE = 2'd0;
	localparam logic [1:0] KIND_MUL  = 2'd1;
	localparam logic [1:0] KIND_DIV  = 2'd2;
	localparam logic [1:0] KIND_MAG  = 2'd3;

	typedef struct packed {
		logic [1:0]  kind;
		logic [31:0] a_re;
		logic [31:0] a_im;
		logic [31:0] b_re;
		logic [31:0] b_im;
		logic [31:0] res_re;
		logic [31:0] res_im;
		logic [1:0]  status;
	} cau_op_t;

	localparam int OP_BITS = $bits(cau_op_t);
endpackage

// File: hdl/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit.
//  channel | direction | tdata fields (low bit up)                     | tuser
//  s_axis  | in        | a_re[31:0] a_im[63:32] b_re[95:64] b_im[127:96] | func[2:0]
//  m_axis  | out       | res_re[31:0] res_im[63:32]                    | status[1:0]
// One item per cycle is accepted and delivered when the output side keeps up.
// Each item passes the queue, two product/sum stages, one stage per quotient bit of
// the divider (2*DATA_WIDTH+FRAC_BITS+2 bits), and rounding.
// Reset clears the queue and the valid flags; payload registers are not reset.
// A stalled output holds the back end; the queue then fills and drops s_axis_tready.
`include "assert_macros.svh"
module complex_arithmetic_unit import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_axis_tuser,  // func
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	output logic [63:0]  m_axis_tdata,  // res_re, res_im
	output logic [1:0]   m_axis_tuser   // status
);
	cau_op_t f_op, q_op;
	logic q_valid, q_ready;

	cau_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
		.func(s_axis_tuser), .a_re(s_axis_tdata[31:0]), .a_im(s_axis_tdata[63:32]),
		.b_re(s_axis_tdata[95:64]), .b_im(s_axis_tdata[127:96]), .op(f_op)
	);

	cau_queue #(.DEPTH(4)) u_queue (
		.clk(clk), .arst_n(arst_n), .wr_valid(s_axis_tvalid), .wr_ready(s_axis_tready),
		.wr_data(f_op), .rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_op)
	);

	cau_back #(.DATA_WIDTH(DATA_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(q_valid), .in_ready(q_ready), .in_op(q_op),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.res_re(m_axis_tdata[31:0]), .res_im(m_axis_tdata[63:32]), .status(m_axis_tuser)
	);

	`ASSERT_IMPL(a_status_code, clk, arst_n, m_axis_tvalid, m_axis_tuser <= STATUS_SAT,
		"status code out of range")
	`ASSERT_NEXT(a_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready,
		m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
	`ASSERT_IMPL(a_dz_zero, clk, arst_n, m_axis_tvalid && m_axis_tuser == STATUS_DZ,
		m_axis_tdata == '0, "divide by zero result not zero")
endmodule

// File: hdl/cau_front.sv
// Front end: decodes the item, finishes the simple operations, sign-extends operands.
module cau_front import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32
) (
	input  logic [2:0]  func,
	input  logic [31:0] a_re,
	input  logic [31:0] a_im,
	input  logic [31:0] b_re,
	input  logic [31:0] b_im,
	output cau_op_t     op
);
	localparam logic signed [DATA_WIDTH:0] POS = {2'b00, {(DATA_WIDTH-1){1'b1}}};
	localparam logic signed [DATA_WIDTH:0] NEG = ~POS;

	logic signed [DATA_WIDTH-1:0] ar, ai, br, bi;
	logic signed [DATA_WIDTH:0] sr, si;
	logic sat_r, sat_i;

	function automatic logic [31:0] sx(input logic signed [DATA_WIDTH-1:0] v);
		sx = 32'(signed'(v));
	endfunction

	function automatic logic [DATA_WIDTH:0] clamp(input logic signed [DATA_WIDTH:0] v,
		output logic s);
		s = 1'b0;
		clamp = v;
		if (v > POS) begin
			s = 1'b1;
			clamp = POS;
		end else if (v < NEG) begin
			s = 1'b1;
			clamp = NEG;
		end
	endfunction

	always_comb begin
		logic [DATA_WIDTH:0] cr, ci;
		ar = a_re[DATA_WIDTH-1:0];
		ai = a_im[DATA_WIDTH-1:0];
		br = b_re[DATA_WIDTH-1:0];
		bi = b_im[DATA_WIDTH-1:0];
		op.a_re = sx(ar);
		op.a_im = sx(ai);
		op.b_re = sx(br);
		op.b_im = sx(bi);
		op.res_re = '0;
		op.res_im = '0;
		op.status = STATUS_OK;
		op.kind = KIND_DONE;
		sr = '0;
		si = '0;
		unique case (func)
			FUNC_ADD: begin
				sr = ar + br;
				si = ai + bi;
			end
			FUNC_SUB: begin
				sr = ar - br;
				si = ai - bi;
			end
			FUNC_CONJ: begin
				sr = ar;
				si = -ai;
			end
			FUNC_MUL: op.kind = KIND_MUL;
			FUNC_DIV: op.kind = KIND_DIV;
			FUNC_MAG: op.kind = KIND_MAG;
			default: ;
		endcase
		cr = clamp(sr, sat_r);
		ci = clamp(si, sat_i);
		op.res_re = sx(cr[DATA_WIDTH-1:0]);
		op.res_im = sx(ci[DATA_WIDTH-1:0]);
		if (sat_r || sat_i)
			op.status = STATUS_SAT;
	end
endmodule

// File: hdl/cau_queue.sv
// Short first-in first-out queue between the front and back ends.
module cau_queue import cau_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    wr_valid,
	output logic    wr_ready,
	input  cau_op_t wr_data,
	output logic    rd_valid,
	input  logic    rd_ready,
	output cau_op_t rd_data
);
	localparam int AW = $clog2(DEPTH);
	cau_op_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0] cnt_q;
	logic push, pop;

	assign wr_ready = cnt_q != (AW+1)'(DEPTH);
	assign rd_valid = cnt_q != '0;
	assign push = wr_valid && wr_ready;
	assign pop = rd_valid && rd_ready;
	assign rd_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= (wp_q == AW'(DEPTH-1)) ? '0 : wp_q + 1'b1;
			if (pop)
				rp_q <= (rp_q == AW'(DEPTH-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(push) - (AW+1)'(pop);
		end
	end
endmodule

// File: hdl/cau_back.sv
// Back end: pipelined products, sums, restoring divider and square root.
module cau_back import cau_pkg::*; #(
	parameter int DATA_WIDTH = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  cau_op_t     in_op,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] res_re,
	output logic [31:0] res_im,
	output logic [1:0]  status
);
	// Widths: products 2W, sums 2W+1 magnitude, dividend shifted by F+1.
	localparam int W = DATA_WIDTH;
	localparam int F = FRAC_BITS;
	localparam int PW = 2 * W + 1;
	localparam int NW = PW + F + 1;
	localparam int QN = PW + F + 1;
	localparam int SQ = (PW + 1) / 2;
	localparam int DEPTH_D = QN;
	localparam int DEPTH_S = SQ;
	localparam int L = (DEPTH_D > DEPTH_S ? DEPTH_D : DEPTH_S) + 3;
	localparam logic [NW-1:0] POSL = NW'({(W-1){1'b1}});
	// One half of the last kept fraction bit.
	localparam logic [NW-1:0] HALF = (NW'(1) << F) >> 1;

	logic adv;
	logic [L-1:0] v_q;
	assign adv = !v_q[L-1] || out_ready;
	assign in_ready = adv;
	assign out_valid = v_q[L-1];

	// Stage 1: products.
	logic [1:0] k_s1;
	cau_op_t o_s1;
	logic signed [2*W-1:0] p_rr, p_ii, p_ri, p_ir, p_ar, p_ai;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [W-1:0] ar, ai, br, bi;
			ar = in_op.a_re[W-1:0];
			ai = in_op.a_im[W-1:0];
			br = in_op.b_re[W-1:0];
			bi = in_op.b_im[W-1:0];
			o_s1 <= in_op;
			k_s1 <= in_op.kind;
			p_rr <= ar * br;
			p_ii <= ai * bi;
			p_ri <= ar * bi;
			p_ir <= ai * br;
			p_ar <= (in_op.kind == KIND_MAG) ? ar * ar : br * br;
			p_ai <= (in_op.kind == KIND_MAG) ? ai * ai : bi * bi;
		end
	end

	// Stage 2: exact sums as sign and magnitude.
	logic [1:0] k_s2;
	cau_op_t o_s2;
	logic ng_r_s2, ng_i_s2, dz_s2;
	logic [PW-1:0] m_r_s2, m_i_s2, den_s2;
	always_ff @(posedge clk) begin
		if (adv) begin
			logic signed [PW:0] sr, si;
			if (k_s1 == KIND_MUL) begin
				sr = p_rr - p_ii;
				si = p_ri + p_ir;
			end else begin
				sr = p_rr + p_ii;
				si = p_ir - p_ri;
			end
			o_s2 <= o_s1;
			k_s2 <= k_s1;
			ng_r_s2 <= sr[PW];
			ng_i_s2 <= si[PW];
			m_r_s2 <= sr[PW] ? PW'(-sr) : sr[PW-1:0];
			m_i_s2 <= si[PW] ? PW'(-si) : si[PW-1:0];
			den_s2 <= PW'($unsigned(p_ar)) + PW'($unsigned(p_ai));
			dz_s2 <= (p_ar == '0) && (p_ai == '0);
		end
	end

	// Iterative pipeline: one quotient bit or one root bit per stage.
	typedef struct packed {
		logic [1:0] kind;
		logic ng_r, ng_i, dz;
		logic [PW-1:0] den;
		logic [PW-1:0] pm_r, pm_i;
		logic [NW-1:0] rr, ri;
		logic [QN-1:0] qr, qi;
		logic [NW-1:0] nr, ni;
		logic [PW+1:0] sx, sres;
		logic [31:0] res_re, res_im;
		logic [1:0] status;
	} it_t;
	it_t it_q [L-3];

	function automatic it_t step(input it_t x, input int n);
		it_t y;
		logic [NW:0] t;
		logic [PW+1:0] b, tr;
		y = x;
		// Restoring division of the dividend scaled by 2^(F+1).
		if (n < QN) begin
			t = {x.rr[NW-2:0], x.nr[NW-1]};
			y.nr = x.nr << 1;
			if (t >= {1'b0, NW'(x.den)}) begin
				y.rr = NW'(t - NW'(x.den));
				y.qr = {x.qr[QN-2:0], 1'b1};
			end else begin
				y.rr = NW'(t);
				y.qr = {x.qr[QN-2:0], 1'b0};
			end
			t = {x.ri[NW-2:0], x.ni[NW-1]};
			y.ni = x.ni << 1;
			if (t >= {1'b0, NW'(x.den)}) begin
				y.ri = NW'(t - NW'(x.den));
				y.qi = {x.qi[QN-2:0], 1'b1};
			end else begin
				y.ri = NW'(t);
				y.qi = {x.qi[QN-2:0], 1'b0};
			end
		end
		// Digit-by-digit square root, one result bit per stage.
		if (n < SQ) begin
			b = (PW+2)'(1) << (2 * (SQ - 1 - n));
			tr = x.sres + b;
			if (x.sx >= tr) begin
				y.sx = x.sx - tr;
				y.sres = (x.sres >> 1) + b;
			end else begin
				y.sres = x.sres >> 1;
			end
		end
		return y;
	endfunction

	it_t it_in;
	always_comb begin
		it_in = '0;
		it_in.kind = k_s2;
		it_in.ng_r = ng_r_s2;
		it_in.ng_i = ng_i_s2;
		it_in.dz = dz_s2;
		it_in.den = den_s2;
		it_in.pm_r = m_r_s2;
		it_in.pm_i = m_i_s2;
		it_in.nr = NW'(m_r_s2) << (F + 1);
		it_in.ni = NW'(m_i_s2) << (F + 1);
		it_in.sx = (PW+2)'(den_s2);
		it_in.res_re = o_s2.res_re;
		it_in.res_im = o_s2.res_im;
		it_in.status = o_s2.status;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			it_q[0] <= step(it_in, 0);
			for (int n = 1; n < L - 3; n++)
				it_q[n] <= step(it_q[n-1], n);
		end
	end

	// Final stage: rounding and saturation.
	function automatic logic [W-1:0] pk(input logic neg, input logic [NW-1:0] m,
		output logic s);
		s = 1'b0;
		if (!neg) begin
			if (m > POSL) begin
				s = 1'b1;
				m = POSL;
			end
			pk = m[W-1:0];
		end else begin
			if (m > POSL + 1'b1) begin
				s = 1'b1;
				m = POSL + 1'b1;
			end
			pk = W'(-m);
		end
	endfunction

	logic [31:0] rr_q, ri_q;
	logic [1:0] st_q;
	always_ff @(posedge clk) begin
		if (adv) begin
			it_t x;
			logic s1, s2;
			logic [NW-1:0] mr, mi;
			logic [W-1:0] vr, vi;
			logic [PW+1:0] rt;
			logic [31:0] o_re, o_im;
			logic [1:0] o_st;
			x = it_q[L-4];
			s1 = 1'b0;
			s2 = 1'b0;
			o_re = x.res_re;
			o_im = x.res_im;
			o_st = x.status;
			unique case (x.kind)
				KIND_MUL: begin
					mr = (NW'(x.pm_r) + HALF) >> F;
					mi = (NW'(x.pm_i) + HALF) >> F;
					vr = pk(x.ng_r, mr, s1);
					vi = pk(x.ng_i, mi, s2);
					o_re = 32'(signed'(vr));
					o_im = 32'(signed'(vi));
					o_st = (s1 || s2) ? STATUS_SAT : STATUS_OK;
				end
				KIND_DIV: begin
					if (x.dz) begin
						o_re = '0;
						o_im = '0;
						o_st = STATUS_DZ;
					end else begin
						mr = NW'((x.qr + 1'b1) >> 1);
						mi = NW'((x.qi + 1'b1) >> 1);
						vr = pk(x.ng_r, mr, s1);
						vi = pk(x.ng_i, mi, s2);
						o_re = 32'(signed'(vr));
						o_im = 32'(signed'(vi));
						o_st = (s1 || s2) ? STATUS_SAT : STATUS_OK;
					end
				end
				KIND_MAG: begin
					// The root's remainder decides the rounding of the root.
					rt = x.sres;
					if (x.sx > rt)
						rt = rt + 1'b1;
					vr = pk(1'b0, NW'(rt), s1);
					o_re = 32'(signed'(vr));
					o_im = '0;
					o_st = s1 ? STATUS_SAT : STATUS_OK;
				end
				default: ;
			endcase
			rr_q <= o_re;
			ri_q <= o_im;
			st_q <= o_st;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_q <= '0;
		else if (adv)
			v_q <= {v_q[L-2:0], in_valid};
	end

	assign res_re = rr_q;
	assign res_im = ri_q;
	assign status = st_q;
endmodule

// File: sim/cau_checker.sv
// Checker for the complex arithmetic unit: predicts each result and compares it with the output.
`timescale 1ns / 100ps
module cau_checker import cau_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // a_re, a_im, b_re, b_im
	input  logic [2:0]   s_axis_tuser,  // func
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [63:0]  m_axis_tdata,  // res_re, res_im
	input  logic [1:0]   m_axis_tuser,  // status
	output int           fail_count,
	output int           pending
);
	typedef struct packed {
		logic [31:0] re;
		logic [31:0] im;
		logic [1:0]  status;
	} cplx_res_t;

	cplx_res_t expected_results[$];

	localparam logic [67:0] POS_LIM = 68'h7FFFFFFF;

	function automatic logic [31:0] saturate(input bit neg, input logic [67:0] mag,
			inout bit sat);
		logic [67:0] neg_mag;
		neg_mag = -mag;
		if (!neg) begin
			if (mag > POS_LIM) begin
				sat = 1'b1;
				return 32'h7FFFFFFF;
			end
			return mag[31:0];
		end
		if (mag > POS_LIM + 68'd1) begin
			sat = 1'b1;
			return 32'h80000000;
		end
		return neg_mag[31:0];
	endfunction

	function automatic logic [31:0] clamp(input logic signed [67:0] v, inout bit sat);
		logic [67:0] mag;
		mag = (v < 0) ? -v : v;
		return saturate(v < 0, mag, sat);
	endfunction

	// Rounds a product sum with twice the fraction bits, ties away from zero.
	function automatic logic [31:0] round_sum(input logic signed [67:0] v, inout bit sat);
		logic [67:0] mag;
		mag = (v < 0) ? -v : v;
		mag = (mag + 68'h8000) >> 16;
		return saturate(v < 0, mag, sat);
	endfunction

	// Quotient num * 2^16 / den, rounded to nearest, ties away from zero.
	function automatic logic [31:0] quotient(input logic signed [67:0] v,
			input logic [67:0] den, inout bit sat);
		logic [67:0] num;
		logic [67:0] q;
		logic [67:0] r;
		bit          qbit;
		num = (v < 0) ? -v : v;
		q = num / den;
		r = num % den;
		if (q > POS_LIM + 68'd1)
			return saturate(v < 0, {68{1'b1}}, sat);
		for (int i = 0; i <= 16; i++) begin
			qbit = (r >= den - r);
			r = qbit ? r - (den - r) : r + r;
			if (i < 16)
				q = (q << 1) | qbit;
			else if (qbit)
				q = q + 68'd1;
		end
		return saturate(v < 0, q, sat);
	endfunction

	function automatic logic [67:0] sqrt_rounded(input logic [67:0] s);
		logic [67:0] root;
		logic [67:0] trial;
		root = '0;
		for (int b = 33; b >= 0; b--) begin
			trial = root | (68'd1 << b);
			if (trial * trial <= s)
				root = trial;
		end
		if (s - root * root > root)
			root = root + 68'd1;
		return root;
	endfunction

	function automatic cplx_res_t compute_complex(input logic [2:0] func, input logic [127:0] d);
		logic signed [67:0] ar, ai, br, bi;
		logic [67:0]        den;
		cplx_res_t          res;
		bit                 sat;
		bit                 dz;
		ar = $signed(d[31:0]);
		ai = $signed(d[63:32]);
		br = $signed(d[95:64]);
		bi = $signed(d[127:96]);
		res = '0;
		sat = 1'b0;
		dz = 1'b0;
		unique case (func)
			FUNC_ADD: begin
				res.re = clamp(ar + br, sat);
				res.im = clamp(ai + bi, sat);
			end
			FUNC_SUB: begin
				res.re = clamp(ar - br, sat);
				res.im = clamp(ai - bi, sat);
			end
			FUNC_MUL: begin
				res.re = round_sum(ar * br - ai * bi, sat);
				res.im = round_sum(ar * bi + ai * br, sat);
			end
			FUNC_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					dz = 1'b1;
				end else begin
					res.re = quotient(ar * br + ai * bi, den, sat);
					res.im = quotient(ai * br - ar * bi, den, sat);
				end
			end
			FUNC_CONJ: begin
				res.re = ar[31:0];
				res.im = clamp(-ai, sat);
			end
			FUNC_MAG: begin
				res.re = saturate(1'b0, sqrt_rounded(ar * ar + ai * ai), sat);
			end
			default: ;
		endcase
		res.status = dz ? STATUS_DZ : (sat ? STATUS_SAT : STATUS_OK);
		return res;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	assign pending = expected_results.size();

	always @(posedge clk) begin
		cplx_res_t want;
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				expected_results.push_back(compute_complex(s_axis_tuser, s_axis_tdata));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected item", m_axis_tdata[31:0], 32'h0);
				end else begin
					want = expected_results.pop_front();
					if (m_axis_tdata[31:0] !== want.re)
						report_mismatch("res_re", m_axis_tdata[31:0], want.re);
					if (m_axis_tdata[63:32] !== want.im)
						report_mismatch("res_im", m_axis_tdata[63:32], want.im);
					if (m_axis_tuser !== want.status)
						report_mismatch("status", {30'd0, m_axis_tuser}, {30'd0, want.status});
				end
			end
		end
	end
endmodule

// File: sim/complex_arithmetic_unit_tb.sv
// Testbench top of the complex arithmetic unit: stimulus, output stalls and verdict.
`timescale 1ns / 100ps
module complex_arithmetic_unit_tb import cau_pkg::*; ();
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 300;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [127:0] s_axis_tdata;
	logic [2:0]   s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [63:0]  m_axis_tdata;
	logic [1:0]   m_axis_tuser;
	int           fail_count;
	int           pending;
	int           send_idle_pct;
	int           recv_idle_pct;
	int           quiet_cycles;

	complex_arithmetic_unit i_dut (.*);

	cau_checker i_checker (.*);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
	end

	always @(posedge clk)
		m_axis_tready <= arst_n && ($urandom_range(99) >= recv_idle_pct);

	// Ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL complex_arithmetic_unit");
			$finish;
		end
	end

	task automatic send_item(input logic [2:0] func, input logic [31:0] a_re,
			input logic [31:0] a_im, input logic [31:0] b_re, input logic [31:0] b_im);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= func;
		s_axis_tdata <= {b_im, b_re, a_im, a_re};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_operand();
		case ($urandom_range(9))
			0: return 32'h7FFFFFFF;
			1: return 32'h80000000;
			2: return 32'h0;
			3, 4: return $urandom_range(32'h3FFFF) - 32'h20000;
			5: return {{8{1'b0}}, 24'($urandom)} - 32'h800000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [2:0] pick_func();
		if ($urandom_range(49) == 0)
			return 3'($urandom_range(7, 6));
		return 3'($urandom_range(5));
	endfunction

	initial begin
		logic [31:0] b_re;
		logic [31:0] b_im;
		logic [2:0]  func;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		send_idle_pct = 33;
		recv_idle_pct = 71;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		@(posedge clk);
		// Extremes, every operation, division by zero, conjugate of the smallest code, unused codes.
		send_item(FUNC_ADD, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000);
		send_item(FUNC_ADD, 32'h00010000, 32'hFFFF0000, 32'h00020000, 32'h00008000);
		send_item(FUNC_SUB, 32'h80000000, 32'h7FFFFFFF, 32'h00000001, 32'hFFFFFFFF);
		send_item(FUNC_SUB, 32'h00030000, 32'h00010000, 32'h00010000, 32'h00030000);
		send_item(FUNC_MUL, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000);
		send_item(FUNC_MUL, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		send_item(FUNC_MUL, 32'h00018000, 32'hFFFF8000, 32'h00010000, 32'h00000001);
		send_item(FUNC_MUL, 32'h00000001, 32'h00000000, 32'h00008000, 32'h00000000);
		send_item(FUNC_DIV, 32'h00010000, 32'h00020000, 32'h00000000, 32'h00000000);
		send_item(FUNC_DIV, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h00000000);
		send_item(FUNC_DIV, 32'h00010000, 32'h00000000, 32'h00030000, 32'h00000000);
		send_item(FUNC_DIV, 32'h80000000, 32'h80000000, 32'h00000001, 32'h00000000);
		send_item(FUNC_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000);
		send_item(FUNC_DIV, 32'h00000001, 32'h00000000, 32'h00020000, 32'h00000000);
		send_item(FUNC_CONJ, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_item(FUNC_CONJ, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_item(FUNC_MAG, 32'h80000000, 32'h80000000, 32'h0, 32'h0);
		send_item(FUNC_MAG, 32'h00030000, 32'h00040000, 32'h0, 32'h0);
		send_item(FUNC_MAG, 32'h00000001, 32'h00000000, 32'h0, 32'h0);
		send_item(FUNC_MAG, 32'h0, 32'h0, 32'h0, 32'h0);
		send_item(3'd6, 32'h12345678, 32'h9ABCDEF0, 32'h0F0F0F0F, 32'hF0F0F0F0);
		send_item(3'd7, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		for (int n = 0; n < 1050; n++) begin
			if (n == 350) begin
				send_idle_pct = 71;
				recv_idle_pct = 33;
			end else if (n == 700) begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
			func = pick_func();
			b_re = pick_operand();
			b_im = pick_operand();
			// Some divisions by zero beyond the directed ones.
			if (func == FUNC_DIV && $urandom_range(19) == 0) begin
				b_re = '0;
				b_im = '0;
			end
			send_item(func, pick_operand(), pick_operand(), b_re, b_im);
		end
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("PASS complex_arithmetic_unit");
		else
			$display("FAIL complex_arithmetic_unit");
		$finish;
	end
endmodule
